// ===== sv/emf_pkg.sv =====
// Shared types and constants of the moving-average and median filter.
`timescale 1ns / 1ps

package emf_pkg;

    // Number of samples in the running median window.
    localparam int unsigned WINDOW_LEN = 5;
    // Width of a count that can hold zero up to the whole window length.
    localparam int unsigned CNT_W = (WINDOW_LEN < 2) ? 1 : $clog2(WINDOW_LEN + 1);

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned GAIN_W   = 17;

    // Gain of exactly 1.0 in Q1.16 and the gain after reset (about 0.1).
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [WINDOW_LEN-1:0]   t_window;
    typedef logic [CNT_W-1:0]           t_count;

endpackage

// ===== sv/emf_median.sv =====
// Median selection over the valid entries of the sample window.
`timescale 1ns / 1ps

module emf_median (
    input  emf_pkg::t_window i_window,  // entry 0 is the newest sample
    input  emf_pkg::t_count  i_count,   // number of valid entries, at least one
    output emf_pkg::t_sample o_median
);

    emf_pkg::t_count rank [emf_pkg::WINDOW_LEN];
    logic            valid [emf_pkg::WINDOW_LEN];
    emf_pkg::t_count target;
    emf_pkg::t_sample sel;

    // Each valid entry gets a unique rank; ties are broken by position.
    always_comb begin
        target = i_count >> 1;
        sel    = '0;
        for (int i = 0; i < emf_pkg::WINDOW_LEN; i++) begin
            valid[i] = (emf_pkg::CNT_W'(i) < i_count);
        end
        for (int i = 0; i < emf_pkg::WINDOW_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < emf_pkg::WINDOW_LEN; j++) begin
                if (j != i && valid[j]) begin
                    if (($signed(i_window[j]) < $signed(i_window[i])) ||
                        ((i_window[j] == i_window[i]) && (j < i))) begin
                        rank[i] = rank[i] + emf_pkg::CNT_W'(1);
                    end
                end
            end
        end
        for (int i = 0; i < emf_pkg::WINDOW_LEN; i++) begin
            if (valid[i] && rank[i] == target) begin
                sel = sel | i_window[i];
            end
        end
    end

    assign o_median = sel;

endmodule

// ===== sv/ema_and_running_median_filter_top.sv =====
// Top level of the exponential moving average and running median filter.
`timescale 1ns / 1ps

// Usage:
// Each word on the slave stream carries one signed 16-bit sample. For every
// accepted word the block returns exactly one word on the master stream with
// the low-pass value (signed, 16 fraction bits) in the low 32 bits and the
// median of the last up to five samples in the next 16 bits.
// The first sample after reset loads the average directly; later samples move
// it toward the new sample by the smoothing gain (Q1.16, 65536 is 1.0, larger
// values act as 1.0). While the window fills, the median is the upper middle.
// The gain is written over the configuration channel, which is always ready;
// write it only while no sample is in flight.
// A word accepted sits in the input register, and its result is loaded into
// the output register and offered on the master stream once that register
// is free or being emptied. One word is accepted every cycle while the
// receiver takes results; the whole update (one 33 by 18 bit multiply and
// the five-entry ranking network) is combinational between the input and
// output registers, so the averaging loop closes through the average register.
// When the receiver stalls, the output register holds its word and the input
// register can still take one more sample; after that tready drops.
// Reset clears the average, the window fill count, the gain (back to about
// 0.1) and all valid flags; window entries are only read once written.

module ema_and_running_median_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream. tdata: [15:0] sample.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    // Master stream. tdata: [31:0] lowpass_out, [47:32] median_out.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,
    // Configuration write channel. data: [16:0] smoothing_gain.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    // Input stage.
    logic             r_in_valid;
    emf_pkg::t_sample r_in_sample;

    // Output stage.
    logic                            r_out_valid;
    logic signed [emf_pkg::ACC_W-1:0] r_out_lowpass;
    emf_pkg::t_sample                r_out_median;

    // Filter state.
    logic signed [emf_pkg::ACC_W-1:0]  r_acc;
    logic                              r_primed;
    emf_pkg::t_window                  r_win;
    emf_pkg::t_count                   r_fill;
    logic [emf_pkg::GAIN_W-1:0]        r_gain;

    logic signed [emf_pkg::ACC_W-1:0]  n_acc;
    emf_pkg::t_window                  n_win;
    emf_pkg::t_count                   n_fill;
    emf_pkg::t_count                   w_count;
    emf_pkg::t_sample                  w_median;

    logic                              w_advance;
    logic [emf_pkg::GAIN_W-1:0]        w_gain;
    logic signed [emf_pkg::ACC_W-1:0]  w_xs;
    logic signed [emf_pkg::ACC_W:0]    w_diff;
    logic signed [50:0]                w_prod;

    // The item in the input register moves on when the output register is
    // free or is being emptied this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // Low-pass update: acc += floor(gain * (x * 65536 - acc) / 65536).
    assign w_gain = (r_gain > emf_pkg::GAIN_ONE) ? emf_pkg::GAIN_ONE : r_gain;
    assign w_xs   = {r_in_sample, 16'd0};
    assign w_diff = (emf_pkg::ACC_W + 1)'(w_xs) - (emf_pkg::ACC_W + 1)'(r_acc);
    assign w_prod = 51'(w_diff) * 51'($signed({1'b0, w_gain}));

    always_comb begin
        if (!r_primed) begin
            n_acc = w_xs;
        end else begin
            // The result stays between the old average and the sample, so
            // the sum is exact in 32 bits.
            n_acc = r_acc + w_prod[47:16];
        end
    end

    // Window update: the newest sample enters at entry zero.
    always_comb begin
        n_win[0] = r_in_sample;
        for (int i = 1; i < emf_pkg::WINDOW_LEN; i++) begin
            n_win[i] = r_win[i-1];
        end
        if (r_fill == emf_pkg::CNT_W'(emf_pkg::WINDOW_LEN)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + emf_pkg::CNT_W'(1);
        end
        w_count = n_fill;
    end

    emf_median u_median (
        .i_window (n_win),
        .i_count  (w_count),
        .o_median (w_median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_primed    <= 1'b0;
            r_fill      <= '0;
            r_gain      <= emf_pkg::GAIN_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_acc       <= n_acc;
                r_primed    <= 1'b1;
                r_fill      <= n_fill;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_sample <= i_s_tdata;
        end
        if (w_advance) begin
            r_win         <= n_win;
            r_out_lowpass <= n_acc;
            r_out_median  <= w_median;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_median, r_out_lowpass};

endmodule

// ===== sim/ema_and_running_median_filter_top_tb.sv =====
// Self-checking testbench of the moving-average and running median filter top level.
`timescale 1ns / 1ps

module ema_and_running_median_filter_top_tb;

    typedef struct {
        logic signed [emf_pkg::ACC_W-1:0] lowpass;
        emf_pkg::t_sample                 median;
    } t_filter_result;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [15:0]                s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [47:0]                m_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [emf_pkg::GAIN_W-1:0] cfg_data;

    // Predicted filter state, kept in step with every accepted sample word.
    logic signed [63:0]         ema_acc;
    logic                       ema_primed;
    emf_pkg::t_sample           win_samples [emf_pkg::WINDOW_LEN];
    int unsigned                win_fill;
    int unsigned                win_oldest;
    logic [emf_pkg::GAIN_W-1:0] gain_reg;

    // Ring of predicted results; the 6-bit pointers wrap on their own.
    t_filter_result exp_ring [64];
    logic [5:0]     exp_wr;
    logic [5:0]     exp_rd;
    int             exp_count;

    int               fail_count;
    bit               src_gaps_on;
    bit               sink_stalls_on;
    int               sink_hold_req;
    int               sink_burst_left;
    emf_pkg::t_sample last_sample;

    ema_and_running_median_filter_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void exp_store(input t_filter_result r);
        exp_ring[exp_wr] = r;
        exp_wr = exp_wr + 6'd1;
        exp_count++;
    endfunction

    function automatic t_filter_result exp_take();
        t_filter_result r;
        r = exp_ring[exp_rd];
        exp_rd = exp_rd + 6'd1;
        exp_count--;
        return r;
    endfunction

    // Median of the filled part of the window; the upper middle while filling.
    function automatic emf_pkg::t_sample window_median();
        emf_pkg::t_sample sorted [emf_pkg::WINDOW_LEN];
        emf_pkg::t_sample v;
        int unsigned      n;
        int               i;
        int               j;
        n = (win_fill > emf_pkg::WINDOW_LEN) ? emf_pkg::WINDOW_LEN : win_fill;
        if (n == 0) return '0;
        for (i = 0; i < n; i++) begin
            v = win_samples[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n/2];
    endfunction

    // Advances the predicted state by one sample and queues the result it gives.
    task automatic predict_filter_step(input emf_pkg::t_sample smp);
        logic signed [63:0] xs;
        logic signed [63:0] diff;
        logic signed [63:0] g;
        logic signed [63:0] prod;
        t_filter_result     res;
        xs = smp;
        xs = xs <<< 16;
        if (!ema_primed) begin
            ema_acc    = xs;
            ema_primed = 1'b1;
        end else begin
            // Gains above one saturate at exactly one.
            g    = (gain_reg > emf_pkg::GAIN_ONE) ? 64'sd65536 : {47'd0, gain_reg};
            diff = xs - ema_acc;
            prod = g * diff;
            ema_acc = ema_acc + (prod >>> 16);
        end
        if (win_oldest >= emf_pkg::WINDOW_LEN) win_oldest = 0;
        if (win_fill < emf_pkg::WINDOW_LEN) begin
            win_samples[(win_oldest + win_fill) % emf_pkg::WINDOW_LEN] = smp;
            win_fill++;
        end else begin
            win_samples[win_oldest] = smp;
            win_oldest = (win_oldest + 1) % emf_pkg::WINDOW_LEN;
        end
        res.lowpass = ema_acc[emf_pkg::ACC_W-1:0];
        res.median  = window_median();
        exp_store(res);
    endtask

    task automatic note_failure(input string what, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what,
                     exp_val, act_val);
    endtask

    // Every sample word taken by the block feeds the predictor.
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready)
            predict_filter_step(emf_pkg::t_sample'(s_tdata));
    end

    always @(posedge clk) begin : check_results
        t_filter_result exp_res;
        if (rst_n && m_tvalid && m_tready) begin
            if (exp_count == 0) begin
                note_failure("unexpected result word", '0, m_tdata[31:0]);
            end else begin
                exp_res = exp_take();
                if (m_tdata[31:0] !== exp_res.lowpass)
                    note_failure("lowpass_out", exp_res.lowpass, m_tdata[31:0]);
                if (m_tdata[47:32] !== exp_res.median)
                    note_failure("median_out", {16'd0, exp_res.median},
                                 {16'd0, m_tdata[47:32]});
            end
        end
    end

    // Receiver: a requested long hold-off first, then random stall bursts.
    always @(negedge clk) begin
        if (sink_hold_req > 0) begin
            m_tready <= 1'b0;
            sink_hold_req--;
        end else if (sink_burst_left > 0) begin
            m_tready <= 1'b0;
            sink_burst_left--;
        end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            sink_burst_left = $urandom_range(1, 15) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one sample word, maybe after an idle burst, and returns once it is taken.
    task automatic send_sample(input emf_pkg::t_sample smp);
        int gap;
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        last_sample = smp;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_count != 0) @(posedge clk);
    endtask

    // Gain writes only happen once every pending result has come back.
    task automatic write_gain(input logic [emf_pkg::GAIN_W-1:0] gain);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= gain;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        gain_reg = gain;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic emf_pkg::t_sample random_sample();
        case ($urandom_range(0, 9)) inside
            0:       return ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7FFF;
            [1:2]:   return emf_pkg::t_sample'($urandom_range(0, 16)) - 16'sd8;
            3:       return last_sample;
            default: return emf_pkg::t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    // The first sample loads the average directly; the window fills one by one.
    task automatic test_first_sample_and_fill();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        wait_idle();
    endtask

    // Zero gain, the smallest gain, unity gain and gains above one with full-scale swings.
    task automatic test_gain_extremes();
        write_gain('0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        write_gain(emf_pkg::GAIN_ONE);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd0);
        write_gain('1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        write_gain(emf_pkg::GAIN_ONE + 1);
        send_sample(16'sd1);
        write_gain(17'd1);
        send_sample(16'sh7FFF);
        wait_idle();
    endtask

    // The receiver holds off while samples keep coming, so the input must stall.
    task automatic test_input_backpressure();
        write_gain(emf_pkg::GAIN_RESET);
        src_gaps_on   = 1'b0;
        sink_hold_req = 300;
        repeat (24) send_sample(random_sample());
        wait_idle();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_gains();
        logic [emf_pkg::GAIN_W-1:0] gains [8];
        int k;
        gains = '{emf_pkg::GAIN_W'($urandom_range(0, 131071)), 17'd0, 17'd65535,
                  emf_pkg::GAIN_ONE, 17'd100000, 17'd1, emf_pkg::GAIN_RESET,
                  emf_pkg::GAIN_W'($urandom_range(0, 65536))};
        for (k = 0; k < 8; k++) begin
            write_gain(gains[k]);
            repeat (100) send_sample(random_sample());
        end
        wait_idle();
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_streaming_no_idle();
        write_gain(emf_pkg::GAIN_W'($urandom_range(0, 131071)));
        src_gaps_on     = 1'b0;
        sink_stalls_on  = 1'b0;
        sink_burst_left = 0;
        repeat (100) send_sample(random_sample());
        wait_idle();
    endtask

    initial begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        fail_count      = 0;
        src_gaps_on     = 1'b1;
        sink_stalls_on  = 1'b1;
        sink_hold_req   = 0;
        sink_burst_left = 0;
        last_sample     = '0;
        ema_acc         = '0;
        ema_primed      = 1'b0;
        win_fill        = 0;
        win_oldest      = 0;
        gain_reg        = emf_pkg::GAIN_RESET;
        exp_wr          = '0;
        exp_rd          = '0;
        exp_count       = 0;
        foreach (win_samples[i]) win_samples[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_sample_and_fill();
        test_gain_extremes();
        test_input_backpressure();
        test_random_gains();
        test_streaming_no_idle();

        // Let any stray result word surface before the verdict.
        repeat (10) @(posedge clk);
        if (fail_count == 0 && exp_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== ema_and_running_median_filter_top.f =====
sv/emf_pkg.sv
sv/emf_median.sv
sv/ema_and_running_median_filter_top.sv
sim/ema_and_running_median_filter_top_tb.sv
